/* src/mfd_pkg.sv */
// Package for the motor feedback frame dispatch block: pipeline depth, field
// widths, register indexes and the types shared by the decode and scale stages.
// No dependencies.
package mfd_pkg;

    localparam int DEF_SLOTS    = 8;
    localparam int MAX_IDS      = 8;     // the id register holds eight nibbles
    localparam int STAGES       = 7;     // decode + six scale stages
    localparam int SCALE_STAGES = STAGES - 1;
    localparam int VAL_W        = 24;    // Q8.16 values
    localparam int MAG_W        = 24;    // magnitude of a range span
    localparam int POS_BITS     = 16;
    localparam int VEL_BITS     = 12;
    localparam int TOR_BITS     = 12;
    localparam int FULL_FRAME   = 8;

    localparam logic [2:0] REG_SLOT_IDS   = 3'd0;
    localparam logic [2:0] REG_SLOT_COUNT = 3'd1;
    localparam logic [2:0] REG_POS_MIN    = 3'd2;
    localparam logic [2:0] REG_POS_MAX    = 3'd3;
    localparam logic [2:0] REG_VEL_MIN    = 3'd4;
    localparam logic [2:0] REG_VEL_MAX    = 3'd5;
    localparam logic [2:0] REG_TOR_MIN    = 3'd6;
    localparam logic [2:0] REG_TOR_MAX    = 3'd7;

    typedef struct packed {
        logic [31:0]              slot_ids;
        logic [3:0]               slot_count;
        logic signed [VAL_W-1:0]  pos_min;
        logic signed [VAL_W-1:0]  pos_max;
        logic signed [VAL_W-1:0]  vel_min;
        logic signed [VAL_W-1:0]  vel_max;
        logic signed [VAL_W-1:0]  tor_min;
        logic signed [VAL_W-1:0]  tor_max;
    } cfg_t;

    // Fields that ride along unchanged to the output.
    typedef struct packed {
        logic                 found;
        logic [2:0]           slot;
        logic [3:0]           fault_state;
        logic [POS_BITS-1:0]  pos_raw;
        logic [VEL_BITS-1:0]  vel_raw;
        logic [TOR_BITS-1:0]  tor_raw;
        logic [7:0]           mos_temp;
        logic [7:0]           coil_temp;
    } meta_t;

    // Operands of one scaling channel: lower end, span sign and magnitude.
    typedef struct packed {
        logic signed [VAL_W-1:0] lo;
        logic                    neg;
        logic [MAG_W-1:0]        mag;
    } span_t;

    typedef struct packed {
        meta_t meta;
        span_t pos;
        span_t vel;
        span_t tor;
    } frame_t;

endpackage

/* src/motor_feedback_frame_dispatch.sv */
// Top level of the motor feedback frame dispatch block: configuration
// registers, stage valid chain and output. Depends on mfd_pkg, mfd_decode, mfd_scale.
//
// One received 8-byte feedback frame enters per cycle and leaves as one result
// transfer; the sustained rate is one frame per clock while out_stall is low.
// The stages follow the scaling path: one stage decodes and matches the
// id, one multiplies the raw code by the range span, and five more divide by
// 2^bits-1 through a rounded first estimate, two refinement steps, a remainder
// correction and the final add of the range lower end. Each stage holds its
// own valid bit, so bubbles close up and a stalled output holds only the
// stages that are full. A frame shorter than eight bytes or with an unknown id
// gives found=0 and all-zero fields. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while no frame is in flight; nothing enforces this.
module motor_feedback_frame_dispatch #(
    parameter int SLOTS = mfd_pkg::DEF_SLOTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         byte_0,
    input  logic [7:0]                         byte_1,
    input  logic [7:0]                         byte_2,
    input  logic [7:0]                         byte_3,
    input  logic [7:0]                         byte_4,
    input  logic [7:0]                         byte_5,
    input  logic [7:0]                         byte_6,
    input  logic [7:0]                         byte_7,
    input  logic [3:0]                         frame_length,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               found,
    output logic [2:0]                         slot,
    output logic [3:0]                         fault_state,
    output logic [mfd_pkg::POS_BITS-1:0]       pos_raw,
    output logic [mfd_pkg::VEL_BITS-1:0]       vel_raw,
    output logic [mfd_pkg::TOR_BITS-1:0]       tor_raw,
    output logic signed [mfd_pkg::VAL_W-1:0]   position,
    output logic signed [mfd_pkg::VAL_W-1:0]   velocity,
    output logic signed [mfd_pkg::VAL_W-1:0]   torque,
    output logic [7:0]                         mos_temp,
    output logic [7:0]                         coil_temp
);
    import mfd_pkg::*;

    cfg_t                 cfg_reg;
    logic [STAGES-1:0]    vld_reg;
    logic [STAGES-1:0]    vld_next;
    logic [STAGES-1:0]    ready;
    meta_t                meta_reg [1:STAGES-1];
    frame_t               frame;

    // Register file: write on enable, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLOT_IDS:   cfg_reg.slot_ids   <= cfg_data;
                REG_SLOT_COUNT: cfg_reg.slot_count <= cfg_data[3:0];
                REG_POS_MIN:    cfg_reg.pos_min    <= cfg_data[VAL_W-1:0];
                REG_POS_MAX:    cfg_reg.pos_max    <= cfg_data[VAL_W-1:0];
                REG_VEL_MIN:    cfg_reg.vel_min    <= cfg_data[VAL_W-1:0];
                REG_VEL_MAX:    cfg_reg.vel_max    <= cfg_data[VAL_W-1:0];
                REG_TOR_MIN:    cfg_reg.tor_min    <= cfg_data[VAL_W-1:0];
                REG_TOR_MAX:    cfg_reg.tor_max    <= cfg_data[VAL_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb
    begin
        ready[STAGES-1] = !vld_reg[STAGES-1] || !out_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            ready[i] = !vld_reg[i] || ready[i+1];
        end
    end

    // Advance valid bits alongside the data; hold a stage that cannot move.
    always_comb
    begin
        vld_next[0] = ready[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            vld_next[i] = ready[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall = !ready[0];

    mfd_decode #(
        .SLOTS (SLOTS)
    ) u_decode (
        .clk          (clk),
        .en           (ready[0]),
        .cfg          (cfg_reg),
        .byte_0       (byte_0),
        .byte_1       (byte_1),
        .byte_2       (byte_2),
        .byte_3       (byte_3),
        .byte_4       (byte_4),
        .byte_5       (byte_5),
        .byte_6       (byte_6),
        .byte_7       (byte_7),
        .frame_length (frame_length),
        .frame        (frame)
    );

    // Carry the pass-through fields down the same stages as the scaling.
    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            meta_reg[1] <= frame.meta;
        end
        for (int i = 2; i < STAGES; i++)
        begin
            if (ready[i])
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    mfd_scale #(
        .CODE_BITS (POS_BITS)
    ) u_scale_pos (
        .clk    (clk),
        .en     (ready[STAGES-1:1]),
        .raw    (frame.meta.pos_raw),
        .span   (frame.pos),
        .result (position)
    );

    mfd_scale #(
        .CODE_BITS (VEL_BITS)
    ) u_scale_vel (
        .clk    (clk),
        .en     (ready[STAGES-1:1]),
        .raw    (frame.meta.vel_raw),
        .span   (frame.vel),
        .result (velocity)
    );

    mfd_scale #(
        .CODE_BITS (TOR_BITS)
    ) u_scale_tor (
        .clk    (clk),
        .en     (ready[STAGES-1:1]),
        .raw    (frame.meta.tor_raw),
        .span   (frame.tor),
        .result (torque)
    );

    assign out_valid   = vld_reg[STAGES-1];
    assign found       = meta_reg[STAGES-1].found;
    assign slot        = meta_reg[STAGES-1].slot;
    assign fault_state = meta_reg[STAGES-1].fault_state;
    assign pos_raw     = meta_reg[STAGES-1].pos_raw;
    assign vel_raw     = meta_reg[STAGES-1].vel_raw;
    assign tor_raw     = meta_reg[STAGES-1].tor_raw;
    assign mos_temp    = meta_reg[STAGES-1].mos_temp;
    assign coil_temp   = meta_reg[STAGES-1].coil_temp;

    // A rejected frame must come out with every field cleared.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> position == '0 && velocity == '0 && torque == '0
                                && slot == '0 && pos_raw == '0 && mos_temp == '0)
        else $error("rejected frame carries nonzero fields");

    // Input is held off only when every stage is occupied.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> &vld_reg)
        else $error("input stalled with an empty stage");

    // A full stage blocked downstream keeps its item.
    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] && !ready[1] |=> vld_reg[1])
        else $error("blocked stage lost its item");

endmodule

/* src/mfd_decode.sv */
// Decode stage: length check, slot id match, field unpack and range spans.
// Depends on mfd_pkg.
module mfd_decode #(
    parameter int SLOTS = mfd_pkg::DEF_SLOTS
) (
    input  logic                clk,
    input  logic                en,
    input  mfd_pkg::cfg_t       cfg,
    input  logic [7:0]          byte_0,
    input  logic [7:0]          byte_1,
    input  logic [7:0]          byte_2,
    input  logic [7:0]          byte_3,
    input  logic [7:0]          byte_4,
    input  logic [7:0]          byte_5,
    input  logic [7:0]          byte_6,
    input  logic [7:0]          byte_7,
    input  logic [3:0]          frame_length,
    output mfd_pkg::frame_t     frame
);
    import mfd_pkg::*;

    localparam int MATCH_SLOTS = (SLOTS < MAX_IDS) ? SLOTS : MAX_IDS;

    frame_t     frame_reg;
    frame_t     frame_next;
    logic       hit;
    logic [2:0] hit_slot;

    function automatic span_t make_span(logic signed [VAL_W-1:0] lo,
                                        logic signed [VAL_W-1:0] hi);
        logic signed [VAL_W:0] diff;
        logic [VAL_W:0]        mag;
        span_t                 s;
        diff  = {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo};
        mag   = diff[VAL_W] ? (~diff + 1'b1) : diff;
        s.lo  = lo;
        s.neg = diff[VAL_W];
        s.mag = mag[MAG_W-1:0];
        return s;
    endfunction

    // Scan downward so the lowest matching slot wins.
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = 3'd0;
        for (int k = MATCH_SLOTS - 1; k >= 0; k--)
        begin
            if ((4'(k) < cfg.slot_count) && (cfg.slot_ids[4*k +: 4] == byte_0[3:0]))
            begin
                hit      = 1'b1;
                hit_slot = 3'(k);
            end
        end
    end

    always_comb
    begin
        frame_next = '0;
        if (hit && (frame_length >= 4'(FULL_FRAME)))
        begin
            frame_next.meta.found       = 1'b1;
            frame_next.meta.slot        = hit_slot;
            frame_next.meta.fault_state = byte_0[7:4];
            frame_next.meta.pos_raw     = {byte_1, byte_2};
            frame_next.meta.vel_raw     = {byte_3, byte_4[7:4]};
            frame_next.meta.tor_raw     = {byte_4[3:0], byte_5};
            frame_next.meta.mos_temp    = byte_6;
            frame_next.meta.coil_temp   = byte_7;
            frame_next.pos              = make_span(cfg.pos_min, cfg.pos_max);
            frame_next.vel              = make_span(cfg.vel_min, cfg.vel_max);
            frame_next.tor              = make_span(cfg.tor_min, cfg.tor_max);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame = frame_reg;

endmodule

/* src/mfd_scale.sv */
// One scaling channel: lo + round(raw * span / (2^CODE_BITS - 1)) over six
// register stages, dividing by the all-ones constant through refinement.
// Depends on mfd_pkg.
module mfd_scale #(
    parameter int CODE_BITS = mfd_pkg::POS_BITS
) (
    input  logic                                clk,
    input  logic [mfd_pkg::SCALE_STAGES-1:0]    en,
    input  logic [CODE_BITS-1:0]                raw,
    input  mfd_pkg::span_t                      span,
    output logic signed [mfd_pkg::VAL_W-1:0]    result
);
    import mfd_pkg::*;

    localparam int XW = CODE_BITS + MAG_W + 1;      // product plus rounding term
    localparam int QW = MAG_W + 1;                  // quotient never exceeds span
    localparam logic [XW-1:0] DIV  = XW'((64'd1 << CODE_BITS) - 64'd1);
    localparam logic [XW-1:0] HALF = XW'(((64'd1 << CODE_BITS) - 64'd2) / 64'd2);

    logic [CODE_BITS+MAG_W-1:0] p_reg;
    logic [XW-1:0]              x3_reg, x4_reg, x5_reg;
    logic [QW-1:0]              q0_reg, q1_reg, q2_reg, q3_reg;
    span_t                      s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    logic signed [VAL_W-1:0]    res_reg;

    logic [XW-1:0]              x3_next;
    logic [QW-1:0]              q0_next, q1_next, q2_next, q3_next;
    logic [XW:0]                sum4, sum5;
    logic [XW:0]                rem6;
    logic signed [QW:0]         off7;
    logic signed [QW:0]         res_wide;

    // x + q >> n converges to floor(x / (2^n - 1)) from below.
    assign x3_next = XW'(p_reg) + HALF;
    assign q0_next = QW'(x3_next >> CODE_BITS);
    assign sum4    = {1'b0, x3_reg} + (XW+1)'(q0_reg);
    assign q1_next = QW'(sum4 >> CODE_BITS);
    assign sum5    = {1'b0, x4_reg} + (XW+1)'(q1_reg);
    assign q2_next = QW'(sum5 >> CODE_BITS);
    // Remainder x - q*(2^n - 1); at most one step short.
    assign rem6    = {1'b0, x5_reg} + (XW+1)'(q2_reg)
                     - ((XW+1)'(q2_reg) << CODE_BITS);
    assign q3_next = (rem6 >= (XW+1)'(DIV)) ? (q2_reg + 1'b1) : q2_reg;
    assign off7    = s6_reg.neg ? -$signed({1'b0, q3_reg}) : $signed({1'b0, q3_reg});
    assign res_wide = (QW+1)'(s6_reg.lo) + off7;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_reg  <= (CODE_BITS+MAG_W)'(raw) * (CODE_BITS+MAG_W)'(span.mag);
            s2_reg <= span;
        end
        if (en[1])
        begin
            x3_reg <= x3_next;
            q0_reg <= q0_next;
            s3_reg <= s2_reg;
        end
        if (en[2])
        begin
            x4_reg <= x3_reg;
            q1_reg <= q1_next;
            s4_reg <= s3_reg;
        end
        if (en[3])
        begin
            x5_reg <= x4_reg;
            q2_reg <= q2_next;
            s5_reg <= s4_reg;
        end
        if (en[4])
        begin
            q3_reg <= q3_next;
            s6_reg <= s5_reg;
        end
        if (en[5])
        begin
            res_reg <= res_wide[VAL_W-1:0];
        end
    end

    assign result = res_reg;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for motor_feedback_frame_dispatch: directed and random feedback
// frames, register settings, idle and back-pressure phases, each result checked field by field.
// Depends on mfd_pkg and motor_feedback_frame_dispatch.
module tb;

    import mfd_pkg::*;

    localparam int TB_SLOTS    = DEF_SLOTS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 2 * STAGES;
    localparam int CHUNK       = 50;

    // One received frame: byte 0 sits in data[0] (the leftmost byte of a literal).
    typedef struct packed {
        logic [0:7][7:0] data;
        logic [3:0]      len;
    } frame_t;

    // One decoded result, in the order of the output ports.
    typedef struct packed {
        logic                 found;
        logic [2:0]           slot;
        logic [3:0]           fault_state;
        logic [POS_BITS-1:0]  pos_raw;
        logic [VEL_BITS-1:0]  vel_raw;
        logic [TOR_BITS-1:0]  tor_raw;
        logic [VAL_W-1:0]     position;
        logic [VAL_W-1:0]     velocity;
        logic [VAL_W-1:0]     torque;
        logic [7:0]           mos_temp;
        logic [7:0]           coil_temp;
    } decode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_SLOT_IDS;
    logic [31:0] cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  byte_0 = '0;
    logic [7:0]  byte_1 = '0;
    logic [7:0]  byte_2 = '0;
    logic [7:0]  byte_3 = '0;
    logic [7:0]  byte_4 = '0;
    logic [7:0]  byte_5 = '0;
    logic [7:0]  byte_6 = '0;
    logic [7:0]  byte_7 = '0;
    logic [3:0]  frame_length = '0;

    // Scaled outputs are kept as raw bit patterns so they compare bit for bit.
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       found;
    logic [2:0]                 slot;
    logic [3:0]                 fault_state;
    logic [POS_BITS-1:0]        pos_raw;
    logic [VEL_BITS-1:0]        vel_raw;
    logic [TOR_BITS-1:0]        tor_raw;
    logic [VAL_W-1:0]           position;
    logic [VAL_W-1:0]           velocity;
    logic [VAL_W-1:0]           torque;
    logic [7:0]                 mos_temp;
    logic [7:0]                 coil_temp;

    // Shadow copy of the register file, updated on every write.
    cfg_t shadow = '0;

    // Decodes of accepted frames still waiting for their result transfer.
    decode_t pending_decodes[$];

    int frames_sent    = 0;
    int frames_matched = 0;
    int results_seen   = 0;
    int settings_used  = 1;
    int error_count    = 0;
    int cycle_count    = 0;

    // Idle knobs, in percent of cycles; hold_request asks for a long receiver hold-off.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    motor_feedback_frame_dispatch #(
        .SLOTS(TB_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .byte_0(byte_0),
        .byte_1(byte_1),
        .byte_2(byte_2),
        .byte_3(byte_3),
        .byte_4(byte_4),
        .byte_5(byte_5),
        .byte_6(byte_6),
        .byte_7(byte_7),
        .frame_length(frame_length),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found(found),
        .slot(slot),
        .fault_state(fault_state),
        .pos_raw(pos_raw),
        .vel_raw(vel_raw),
        .tor_raw(tor_raw),
        .position(position),
        .velocity(velocity),
        .torque(torque),
        .mos_temp(mos_temp),
        .coil_temp(coil_temp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Scale a raw code into [lo, hi]: lo + round(code * (hi - lo) / (2^bits - 1)).
    // The divisor is odd, so rounding never meets a tie.
    function automatic logic [VAL_W-1:0] scale_code(input longint code,
                                                    input logic signed [VAL_W-1:0] lo,
                                                    input logic signed [VAL_W-1:0] hi,
                                                    input int bits);
        longint span;
        longint div;
        longint mag;
        longint quo;
        longint sum;
        span = longint'(hi) - longint'(lo);
        div  = (longint'(1) << bits) - 1;
        mag  = (span < 0) ? -span : span;
        quo  = (2 * code * mag + div) / (2 * div);
        sum  = longint'(lo) + ((span < 0) ? -quo : quo);
        return sum[VAL_W-1:0];
    endfunction

    // Expected decode of one frame under the current shadow registers.
    function automatic decode_t decode_feedback(input frame_t f);
        decode_t    r;
        int         used;
        int         k;
        logic [3:0] id;
        r = '0;
        // Short frame: everything stays zero. Lengths above eight count as eight.
        if (f.len < FULL_FRAME)
            return r;
        used = shadow.slot_count;
        if (used > TB_SLOTS)
            used = TB_SLOTS;
        if (used > MAX_IDS)
            used = MAX_IDS;
        id = f.data[0][3:0];
        k = 0;
        while (k < used && shadow.slot_ids[4*k +: 4] != id)
            k++;
        // No slot in use carries this id: same as a short frame.
        if (k >= used)
            return r;
        r.found       = 1'b1;
        r.slot        = k[2:0];
        r.fault_state = f.data[0][7:4];
        r.pos_raw     = {f.data[1], f.data[2]};
        r.vel_raw     = {f.data[3], f.data[4][7:4]};
        r.tor_raw     = {f.data[4][3:0], f.data[5]};
        r.position    = scale_code(longint'(r.pos_raw), shadow.pos_min, shadow.pos_max, POS_BITS);
        r.velocity    = scale_code(longint'(r.vel_raw), shadow.vel_min, shadow.vel_max, VEL_BITS);
        r.torque      = scale_code(longint'(r.tor_raw), shadow.tor_min, shadow.tor_max, TOR_BITS);
        r.mos_temp    = f.data[6];
        r.coil_temp   = f.data[7];
        return r;
    endfunction

    function automatic frame_t make_frame(input logic [63:0] bytes, input logic [3:0] len);
        frame_t f;
        f.data = bytes;
        f.len  = len;
        return f;
    endfunction

    // Random byte, biased toward the all-zero and all-one codes now and then.
    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 6)
            return 8'h00;
        if (pick < 12)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed frames addressed to a slot in use; the rest short, long or stray.
    function automatic frame_t rand_frame();
        frame_t f;
        int     used;
        int     pick;
        int     k;
        for (int i = 0; i < 8; i++)
            f.data[i] = rand_byte();
        pick = $urandom_range(99);
        if (pick < 80)
            f.len = 4'(FULL_FRAME);
        else if (pick < 90)
            f.len = 4'($urandom_range(FULL_FRAME - 1));
        else
            f.len = 4'($urandom_range(15, FULL_FRAME + 1));
        used = (shadow.slot_count > MAX_IDS) ? MAX_IDS : shadow.slot_count;
        if (used > 0 && $urandom_range(99) < 80)
        begin
            k = $urandom_range(used - 1);
            f.data[0][3:0] = shadow.slot_ids[4*k +: 4];
        end
        return f;
    endfunction

    function automatic logic [VAL_W-1:0] rand_range_end();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return {1'b1, {(VAL_W-1){1'b0}}};
        if (pick < 30)
            return {1'b0, {(VAL_W-1){1'b1}}};
        if (pick < 50)
            return VAL_W'($urandom_range(2 * (1 << 20)) - (1 << 20));
        return VAL_W'($urandom);
    endfunction

    // Offer one frame and hold it until the transfer; leave valid high on return so that
    // back-to-back frames need no second assignment in the same step.
    task automatic send_frame(input frame_t f);
        decode_t want;
        want = decode_feedback(f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        byte_0       <= f.data[0];
        byte_1       <= f.data[1];
        byte_2       <= f.data[2];
        byte_3       <= f.data[3];
        byte_4       <= f.data[4];
        byte_5       <= f.data[5];
        byte_6       <= f.data[6];
        byte_7       <= f.data[7];
        frame_length <= f.len;
        do
            @(posedge clk);
        while (in_stall);
        pending_decodes.push_back(want);
        frames_sent++;
        if (want.found)
            frames_matched++;
    endtask

    // Drop valid and wait until every result is back and the DRAIN_WAIT idle period is over.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Write one register; upper data bits beyond the register width are don't-care
    // and get random filler so that every bit of the port toggles.
    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        logic [31:0] word;
        word = value;
        if (index == REG_SLOT_COUNT)
            word = {28'($urandom), value[3:0]};
        else if (index != REG_SLOT_IDS)
            word = {8'($urandom_range(255)), value[VAL_W-1:0]};
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= word;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_SLOT_IDS:   shadow.slot_ids   = word;
            REG_SLOT_COUNT: shadow.slot_count = word[3:0];
            REG_POS_MIN:    shadow.pos_min    = word[VAL_W-1:0];
            REG_POS_MAX:    shadow.pos_max    = word[VAL_W-1:0];
            REG_VEL_MIN:    shadow.vel_min    = word[VAL_W-1:0];
            REG_VEL_MAX:    shadow.vel_max    = word[VAL_W-1:0];
            REG_TOR_MIN:    shadow.tor_min    = word[VAL_W-1:0];
            REG_TOR_MAX:    shadow.tor_max    = word[VAL_W-1:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    // Load a whole setting; the pipeline is drained first.
    task automatic program_setting(input cfg_t c);
        drain_pipeline();
        write_reg(REG_SLOT_IDS,   c.slot_ids);
        write_reg(REG_SLOT_COUNT, {28'd0, c.slot_count});
        write_reg(REG_POS_MIN,    {8'd0, c.pos_min});
        write_reg(REG_POS_MAX,    {8'd0, c.pos_max});
        write_reg(REG_VEL_MIN,    {8'd0, c.vel_min});
        write_reg(REG_VEL_MAX,    {8'd0, c.vel_max});
        write_reg(REG_TOR_MIN,    {8'd0, c.tor_min});
        write_reg(REG_TOR_MAX,    {8'd0, c.tor_max});
        settings_used++;
    endtask

    // Random frames in chunks, each chunk under a fresh random setting.
    task automatic send_random_frames(input int count);
        cfg_t c;
        for (int i = 0; i < count; i++)
        begin
            if (i % CHUNK == 0)
            begin
                c.slot_ids   = $urandom;
                c.slot_count = ($urandom_range(99) < 75) ? 4'($urandom_range(8, 1))
                                                         : 4'($urandom_range(15));
                c.pos_min    = rand_range_end();
                c.pos_max    = rand_range_end();
                c.vel_min    = rand_range_end();
                c.vel_max    = rand_range_end();
                c.tor_min    = rand_range_end();
                c.tor_max    = rand_range_end();
                program_setting(c);
            end
            send_frame(rand_frame());
        end
    endtask

    // Registers at their reset value: no slot in use, so nothing matches.
    task automatic test_reset_state();
        send_frame(make_frame(64'h0000_0000_0000_0000, 4'd8));
        send_frame(make_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd15));
        send_frame(make_frame(64'h5A5A_5A5A_5A5A_5A5A, 4'd3));
    endtask

    // Field extremes, first-match priority on duplicate ids, short and long lengths,
    // a reversed velocity range and the widest position range.
    task automatic test_directed_frames();
        cfg_t c;
        c.slot_ids   = 32'hF0A5_53C1;    // slots 3 and 4 both carry id 5
        c.slot_count = 4'd8;
        c.pos_min    = 24'h80_0000;
        c.pos_max    = 24'h7F_FFFF;
        c.vel_min    = 24'h7F_FFFF;
        c.vel_max    = 24'h80_0000;
        c.tor_min    = -24'sd819200;
        c.tor_max    = 24'sd819200;
        program_setting(c);
        send_frame(make_frame(64'h0100_0000_0000_0000, 4'd8));  // all codes zero
        send_frame(make_frame(64'hFFFF_FFFF_FFFF_FFFF, 4'd8));  // all codes full scale
        send_frame(make_frame(64'h7580_0080_0800_1E64, 4'd8));  // mid codes, duplicate id
        send_frame(make_frame(64'h3212_3456_789A_BCDE, 4'd8));  // id not configured
        send_frame(make_frame(64'h01FF_FFFF_FFFF_FFFF, 4'd0));  // empty frame
        send_frame(make_frame(64'h01FF_FFFF_FFFF_FFFF, 4'd7));  // one byte short
        send_frame(make_frame(64'hC3AB_CDEF_0123_4567, 4'd9));  // long length counts as eight
        send_frame(make_frame(64'h8A00_0100_1001_FF00, 4'd15));
        send_frame(make_frame(64'hE0FF_FE00_0FF0_00FF, 4'd8));  // id zero, slot 6
        send_frame(make_frame(64'h9C00_0100_0000_1080, 4'd8));  // smallest nonzero position code
        send_frame(make_frame(64'h63FF_FEFF_EFFE_2A2A, 4'd8));  // one below full scale
    endtask

    // Slot count above eight uses eight; small counts hide the upper slots.
    task automatic test_slot_count_limits();
        cfg_t c;
        c = shadow;
        c.slot_count = 4'd15;
        program_setting(c);
        send_frame(make_frame(64'h4FAA_5555_AA55_0FF0, 4'd8));
        send_frame(make_frame(64'h1234_5678_9ABC_DEF0, 4'd8));
        c.slot_count = 4'd3;
        c.pos_min    = 24'sd0;
        c.pos_max    = 24'sd0;      // zero span: every code lands on the lower end
        program_setting(c);
        send_frame(make_frame(64'h5511_2233_4455_6677, 4'd8));  // slot 3 not in use
        send_frame(make_frame(64'h2300_FFFF_F00F_8001, 4'd8));  // slot 2
        c.slot_count = 4'd0;
        program_setting(c);
        send_frame(make_frame(64'h0100_0000_0000_0000, 4'd8));
    endtask

    task automatic test_streaming();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_frames(200);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 83;
        recv_stall_pct = 0;
        send_random_frames(200);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        send_random_frames(200);
    endtask

    task automatic test_light_idle();
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        send_random_frames(150);
    endtask

    // Hold the receiver off long enough for the pipeline to fill while frames keep coming.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_pipeline();
        hold_request = 300;
        send_random_frames(100);
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each result transfer against the oldest pending decode.
    always @(posedge clk)
    begin : check_results
        decode_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            results_seen++;
            if (pending_decodes.size() == 0)
            begin
                $display("%0t: result transfer with no frame pending, found=%0b slot=%0d",
                         $time, found, slot);
                error_count++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                check_field("found",       want.found,       found);
                check_field("slot",        want.slot,        slot);
                check_field("fault_state", want.fault_state, fault_state);
                check_field("pos_raw",     want.pos_raw,     pos_raw);
                check_field("vel_raw",     want.vel_raw,     vel_raw);
                check_field("tor_raw",     want.tor_raw,     tor_raw);
                check_field("position",    want.position,    position);
                check_field("velocity",    want.velocity,    velocity);
                check_field("torque",      want.torque,      torque);
                check_field("mos_temp",    want.mos_temp,    mos_temp);
                check_field("coil_temp",   want.coil_temp,   coil_temp);
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results pending", $time, pending_decodes.size());
            $display("motor_feedback_frame_dispatch: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_frames();
        test_slot_count_limits();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_light_idle();
        test_backpressure();
        drain_pipeline();

        if (pending_decodes.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_decodes.size());
            error_count++;
        end
        $display("Covered %0d frames (%0d matched a slot, %0d results checked) under %0d settings,",
                 frames_sent, frames_matched, results_seen, settings_used);
        $display("with free flow, sender gaps, receiver stalls and a long receiver hold-off.");
        if (error_count == 0)
            $display("motor_feedback_frame_dispatch: match");
        else
            $display("motor_feedback_frame_dispatch: mismatch");
        $finish;
    end

endmodule

/* files.f */
src/mfd_pkg.sv
src/mfd_decode.sv
src/mfd_scale.sv
src/motor_feedback_frame_dispatch.sv
tb/sv/tb.sv
